[rtl/sapq_pkg.sv]
// Shared types and constants for the sorted array priority queue.
// Used by sapq_front, sapq_back and sorted_array_priority_queue.
package sapq_pkg;

    localparam int OP_W        = 2;
    localparam int VALUE_W     = 32;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 40;

    // op codes on the input channel
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        K_INSERT,
        K_DELETE,
        K_DUMP,
        K_NOP
    } op_kind_t;

    typedef struct packed {
        op_kind_t                   kind;
        logic signed [VALUE_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0]        status;
        logic signed [VALUE_W-1:0]  entry;
        logic [COUNT_W-1:0]         count;
        logic                       last;
    } res_t;

    typedef enum logic {
        BK_RUN,
        BK_DUMP
    } back_state_t;

endpackage

[rtl/sapq_front.sv]
// Front end: accepts items, decodes op into a command kind, and holds
// them in a two-entry queue for the back end. Depends on sapq_pkg.
module sapq_front import sapq_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [OP_W-1:0]            in_op,
    input  logic signed [VALUE_W-1:0]  in_value,
    output logic                       cmd_valid,
    output cmd_t                       cmd,
    input  logic                       cmd_pop
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    cmd_t       decoded;

    always_comb begin
        decoded.value = in_value;
        unique case (in_op)
            OP_INSERT: decoded.kind = K_INSERT;
            OP_DELETE: decoded.kind = K_DELETE;
            OP_DUMP:   decoded.kind = K_DUMP;
            OP_NOP:    decoded.kind = K_NOP;
            default:   decoded.kind = K_NOP;
        endcase
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = cmd_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= decoded;
        end
    end

endmodule

[rtl/sapq_back.sv]
// Back end: the sorted cell row, the dump sequencer and the result register.
// Depends on sapq_pkg.
module sapq_back import sapq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   cmd_valid,
    input  cmd_t   cmd,
    output logic   cmd_pop,
    output logic   res_valid,
    output res_t   res,
    input  logic   res_ready
);

    localparam int FW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [VALUE_W-1:0] cell_reg [DEPTH];
    logic signed [VALUE_W-1:0] cell_next [DEPTH];
    logic signed [VALUE_W-1:0] ins_val [DEPTH];
    logic signed [VALUE_W-1:0] del_val [DEPTH];
    logic [DEPTH-1:0]          ge, eq, live, ins_m;

    logic [FW-1:0]   fill_reg, fill_next;
    logic [IW-1:0]   idx_reg, idx_next;
    back_state_t     state_reg, state_next;
    logic            valid_reg, valid_next;
    res_t            res_reg, res_next;

    logic            can_load, full, found, dump_last;

    // per-cell compare and neighbor selection
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        assign ge[i]    = (cmd.value >= cell_reg[i]);
        assign live[i]  = (FW'(i) < fill_reg);
        assign eq[i]    = (cmd.value == cell_reg[i]) && live[i];
        // cells holding a value <= the new one, and free cells: the insertion point and every cell after it
        assign ins_m[i] = ge[i] | ~live[i];
        if (i == 0) begin : g_head
            assign ins_val[i] = cmd.value;
        end else begin : g_body
            assign ins_val[i] = ins_m[i-1] ? cell_reg[i-1] : cmd.value;
        end
        if (i == DEPTH - 1) begin : g_tail
            assign del_val[i] = cell_reg[i];
        end else begin : g_mid
            assign del_val[i] = cell_reg[i+1];
        end
    end

    assign can_load  = !valid_reg || res_ready;
    assign full      = (fill_reg == FW'(DEPTH));
    assign found     = |eq;
    assign dump_last = ((FW'(idx_reg) + FW'(1)) == fill_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_RUN: begin
                if (cmd_valid && can_load && cmd.kind == K_DUMP && fill_reg != '0) begin
                    state_next = BK_DUMP;
                end
            end
            BK_DUMP: begin
                if (can_load && dump_last) begin
                    state_next = BK_RUN;
                end
            end
            default: state_next = BK_RUN;
        endcase
    end

    // datapath and outputs
    always_comb begin
        cell_next  = cell_reg;
        fill_next  = fill_reg;
        idx_next   = idx_reg;
        cmd_pop    = 1'b0;
        valid_next = valid_reg && !res_ready;
        res_next   = res_reg;

        unique case (state_reg)
            BK_RUN: begin
                if (cmd_valid && can_load) begin
                    res_next.status = ST_OK;
                    res_next.entry  = '0;
                    res_next.last   = 1'b1;
                    valid_next      = 1'b1;
                    cmd_pop         = 1'b1;
                    unique case (cmd.kind)
                        K_INSERT: begin
                            if (full) begin
                                res_next.status = ST_OVERFLOW;
                            end else begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (ins_m[i]) begin
                                        cell_next[i] = ins_val[i];
                                    end
                                end
                                fill_next = fill_reg + FW'(1);
                            end
                        end
                        K_DELETE: begin
                            if (fill_reg == '0) begin
                                res_next.status = ST_EMPTY;
                            end else if (found) begin
                                for (int i = 0; i < DEPTH; i++) begin
                                    if (ge[i]) begin
                                        cell_next[i] = del_val[i];
                                    end
                                end
                                fill_next = fill_reg - FW'(1);
                            end else begin
                                res_next.status = ST_NOTFOUND;
                            end
                        end
                        K_DUMP: begin
                            if (fill_reg == '0) begin
                                res_next.status = ST_EMPTY;
                            end else begin
                                // item stays queued until its last entry goes out
                                valid_next = valid_reg && !res_ready;
                                res_next   = res_reg;
                                cmd_pop    = 1'b0;
                                idx_next   = '0;
                            end
                        end
                        K_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                    res_next.count = COUNT_W'(fill_next);
                end
            end
            BK_DUMP: begin
                if (can_load) begin
                    valid_next      = 1'b1;
                    res_next.status = ST_OK;
                    res_next.entry  = cell_reg[idx_reg];
                    res_next.count  = COUNT_W'(fill_reg);
                    res_next.last   = dump_last;
                    if (dump_last) begin
                        cmd_pop = 1'b1;
                    end else begin
                        idx_next = idx_reg + IW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign res_valid = valid_reg;
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_RUN;
            fill_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg <= cell_next;
        idx_reg  <= idx_next;
        res_reg  <= res_next;
    end

endmodule

[rtl/sorted_array_priority_queue.sv]
// Top level of the sorted array priority queue: stream ports, field packing.
// Depends on sapq_pkg, sapq_front and sapq_back.
//
// Usage: each input item carries an op and a 32-bit signed value. Insert
// places the value in a descending sorted row of DEPTH cells (equal values
// go in front of those already stored); delete removes one entry equal to
// the value; dump sends every stored entry, highest first. Every item
// answers with result items on the m_ channel; m_tlast marks the final
// result of each item. Insert, delete and an unused op answer with one
// result, dump with one result per stored entry (one empty status if none).
// Items enter a two-entry queue, so the input keeps accepting while a
// result waits for the receiver. For insert and delete, every cell in the
// cell row compares against the value in parallel and shifts its neighbor
// in or out. The item is registered in a queue slot and its result in the
// result register, where m_tvalid rises. Throughput is one item per cycle
// for insert and delete while m_tready stays high; a dump first starts the
// dump sequencer, then sends each stored entry in turn through the result
// register. When m_tready is low the result register holds and the queue
// fills, then s_tready drops. Reset empties the queue and the row (fill
// goes to zero); stored values are not cleared.
module sorted_array_priority_queue import sapq_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // op[1:0], value[33:2], zero[39:34]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status[1:0], entry[33:2], count[37:34]
    output logic                   m_tlast
);

    logic                      cmd_valid;
    logic                      cmd_pop;
    cmd_t                      cmd;
    res_t                      res;
    logic [OP_W-1:0]           in_op;
    logic signed [VALUE_W-1:0] in_value;

    // unpack the input item
    assign in_op    = s_tdata[OP_W-1:0];
    assign in_value = s_tdata[OP_W+VALUE_W-1:OP_W];

    sapq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (in_op),
        .in_value  (in_value),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    sapq_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .res_valid (m_tvalid),
        .res       (res),
        .res_ready (m_tready)
    );

    // pack the result item, padding to whole bytes
    assign m_tdata = {
        {(OUT_TDATA_W - STATUS_W - VALUE_W - COUNT_W){1'b0}},
        res.count,
        res.entry,
        res.status
    };
    assign m_tlast = res.last;

endmodule
